FILE: rtl/core/nmt_pkg.sv
package nmt_pkg;

	// operation codes
	localparam logic [1:0] OP_INSERT     = 2'd0;
	localparam logic [1:0] OP_LOOKUP_EXT = 2'd1;
	localparam logic [1:0] OP_LOOKUP_INT = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// result source select
	localparam logic [1:0] RES_EMPTY  = 2'd0;
	localparam logic [1:0] RES_INSERT = 2'd1;
	localparam logic [1:0] RES_HIT    = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic        map_type;
		logic [31:0] int_addr;
		logic [15:0] int_port;
		logic [15:0] ext_port;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  hit_index;
		logic [31:0] hit_int_addr;
		logic [15:0] hit_int_port;
		logic [15:0] hit_ext_port;
	} rsp_t;

	typedef struct packed {
		logic       cap_req;
		logic       exec_insert;
		logic       scan_start;
		logic       scan_run;
		logic       res_load;
		logic [1:0] res_sel;
		logic [1:0] res_status;
		logic       out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       cnt_zero;
		logic       hit;
		logic       last_miss;
		logic       out_free;
	} dp_stat_t;

endpackage

FILE: rtl/core/nmt_datapath.sv
module nmt_datapath
	import nmt_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  logic     rsp_ready,
	output logic     rsp_valid,
	output rsp_t     rsp,
	input  ctl_cmd_t cmd,
	output dp_stat_t stat
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [31:0] addr_mem [TABLE_DEPTH];
	logic [32:0] port_mem [TABLE_DEPTH];

	req_t             req_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] ptr_q;
	logic             issue_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_slot_s1;
	logic [31:0]      rd_addr_s1;
	logic [32:0]      rd_port_s1;
	rsp_t             res_q;
	rsp_t             out_q;
	logic             out_vld_q;

	logic [IDX_W-1:0]   wr_slot;
	logic [CNT_W-1:0]   cnt_m1;
	logic               match;
	logic [IDX_W+5:0]   wr_idx_ext;
	logic [IDX_W+5:0]   rd_idx_ext;

	assign wr_slot    = cnt_q[IDX_W-1:0];
	assign cnt_m1     = cnt_q - CNT_W'(1);
	assign wr_idx_ext = {6'b0, wr_slot};
	assign rd_idx_ext = {6'b0, rd_slot_s1};

	always_comb begin
		match = (rd_port_s1[32] == req_q.map_type);
		if (req_q.operation == OP_LOOKUP_EXT) begin
			match = match && (rd_port_s1[31:16] == req_q.ext_port);
		end else begin
			match = match && (rd_port_s1[15:0] == req_q.int_port)
				&& (rd_addr_s1 == req_q.int_addr);
		end
	end

	assign stat.op        = req_q.operation;
	assign stat.full      = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign stat.cnt_zero  = (cnt_q == '0);
	assign stat.hit       = rd_vld_s1 && match;
	assign stat.last_miss = rd_vld_s1 && !match && (rd_slot_s1 == '0);
	assign stat.out_free  = !out_vld_q || rsp_ready;

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.exec_insert) begin
			addr_mem[wr_slot] <= req_q.int_addr;
			port_mem[wr_slot] <= {req_q.map_type, req_q.ext_port, req_q.int_port};
		end
		rd_addr_s1 <= addr_mem[ptr_q];
		rd_port_s1 <= port_mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			issue_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.exec_insert) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			rd_vld_s1 <= cmd.scan_run && issue_q;
			if (cmd.scan_start) begin
				issue_q <= 1'b1;
			end else if (cmd.scan_run && issue_q && ptr_q == '0) begin
				issue_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_req) begin
			req_q <= req;
		end
		// walk from the newest slot down to slot zero
		if (cmd.scan_start) begin
			ptr_q <= cnt_m1[IDX_W-1:0];
		end else if (cmd.scan_run && issue_q) begin
			ptr_q <= ptr_q - IDX_W'(1);
		end
		rd_slot_s1 <= ptr_q;
		if (cmd.res_load) begin
			res_q.status <= cmd.res_status;
			case (cmd.res_sel)
				RES_INSERT: begin
					res_q.hit_index    <= wr_idx_ext[5:0];
					res_q.hit_int_addr <= req_q.int_addr;
					res_q.hit_int_port <= req_q.int_port;
					res_q.hit_ext_port <= req_q.ext_port;
				end
				RES_HIT: begin
					res_q.hit_index    <= rd_idx_ext[5:0];
					res_q.hit_int_addr <= rd_addr_s1;
					res_q.hit_int_port <= rd_port_s1[15:0];
					res_q.hit_ext_port <= rd_port_s1[31:16];
				end
				default: begin
					res_q.hit_index    <= '0;
					res_q.hit_int_addr <= '0;
					res_q.hit_int_port <= '0;
					res_q.hit_ext_port <= '0;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

endmodule

FILE: rtl/core/nmt_ctrl.sv
module nmt_ctrl
	import nmt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.cap_req = req_valid;
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d      = S_DONE;
				cmd.res_sel  = RES_EMPTY;
				cmd.res_status = ST_NOT_FOUND;
				case (stat.op) inside
					OP_INSERT: begin
						cmd.res_load = 1'b1;
						if (stat.full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.exec_insert = 1'b1;
							cmd.res_sel     = RES_INSERT;
							cmd.res_status  = ST_OK;
						end
					end
					OP_LOOKUP_EXT, OP_LOOKUP_INT: begin
						if (stat.cnt_zero) begin
							cmd.res_load = 1'b1;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					default: begin
						cmd.res_load = 1'b1;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.hit) begin
					cmd.res_load   = 1'b1;
					cmd.res_sel    = RES_HIT;
					cmd.res_status = ST_OK;
					state_d        = S_DONE;
				end else if (stat.last_miss) begin
					cmd.res_load   = 1'b1;
					cmd.res_sel    = RES_EMPTY;
					cmd.res_status = ST_NOT_FOUND;
					state_d        = S_DONE;
				end
			end
			S_DONE: begin
				// hold until the output register is free
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/core/nat_mapping_table_unit.sv
// NAT mapping table.
// Input channel req_valid/req_ready/req carries one item: an insert, a
// lookup by kind and external port, or a lookup by kind, internal address
// and internal port. Output channel rsp_valid/rsp_ready/rsp returns exactly
// one result item per input item, in order.
// Inserts fill slots 0, 1, 2, ... and are refused with status full once
// TABLE_DEPTH slots are taken. A lookup walks the filled slots from the
// newest down, one table memory read per cycle, so the newest match wins.
// One item is in work at a time; req_ready rises again in the cycle that
// rsp_valid rises. The rate is set by the single read port of the table
// memory. A finished result waits in the output register while the next
// item is accepted; if rsp_ready stays low, that next result holds inside
// until the output register frees up. Reset empties the table at once
// (fill count to zero); the entries themselves are not cleared.
module nat_mapping_table_unit
	import nmt_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	nmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	nmt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.stat      (stat)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("accepted a second item while busy");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec_insert |-> !stat.full)
		else $error("insert written into a full table");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp_valid || rsp_ready))
		else $error("pending result overwritten");

	a_empty_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.hit_index == '0 && rsp.hit_int_addr == '0
			&& rsp.hit_int_port == '0 && rsp.hit_ext_port == '0)
		else $error("non-zero fields on a failed item");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

import nmt_pkg::*;

class nat_table_scoreboard #(int DEPTH = 64);
	logic [31:0] addr_tbl [DEPTH];
	logic        kind_tbl [DEPTH];
	logic [15:0] int_port_tbl [DEPTH];
	logic [15:0] ext_port_tbl [DEPTH];
	int          fill;
	rsp_t        expected_rsp_q [$];
	int          fail_count;

	function new();
		fill = 0;
		fail_count = 0;
	endfunction

	function rsp_t load_slot(int s);
		rsp_t res;
		res.status       = ST_OK;
		res.hit_index    = 6'(s);
		res.hit_int_addr = addr_tbl[s];
		res.hit_int_port = int_port_tbl[s];
		res.hit_ext_port = ext_port_tbl[s];
		return res;
	endfunction

	// newest slot wins on lookup; refused insert leaves the table alone
	function rsp_t predict_translation(req_t r);
		rsp_t res;
		int   s;
		res = '0;
		res.status = ST_NOT_FOUND;
		case (r.operation)
			OP_INSERT: begin
				if (fill >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					addr_tbl[fill]     = r.int_addr;
					kind_tbl[fill]     = r.map_type;
					int_port_tbl[fill] = r.int_port;
					ext_port_tbl[fill] = r.ext_port;
					res = load_slot(fill);
					fill++;
				end
			end
			OP_LOOKUP_EXT: begin
				for (s = fill - 1; s >= 0; s--) begin
					if (kind_tbl[s] == r.map_type && ext_port_tbl[s] == r.ext_port)
						return load_slot(s);
				end
			end
			OP_LOOKUP_INT: begin
				for (s = fill - 1; s >= 0; s--) begin
					if (kind_tbl[s] == r.map_type && int_port_tbl[s] == r.int_port
					    && addr_tbl[s] == r.int_addr)
						return load_slot(s);
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function void note_request(req_t r);
		expected_rsp_q.push_back(predict_translation(r));
	endfunction

	function void compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
			fail_count++;
		end
	endfunction

	function void check_response(rsp_t got);
		rsp_t want;
		if (expected_rsp_q.size() == 0) begin
			$display("%0t unexpected result: expected none actual %0h", $time, got);
			fail_count++;
			return;
		end
		want = expected_rsp_q.pop_front();
		compare_field("status", 32'(want.status), 32'(got.status));
		compare_field("hit_index", 32'(want.hit_index), 32'(got.hit_index));
		compare_field("hit_int_addr", want.hit_int_addr, got.hit_int_addr);
		compare_field("hit_int_port", 32'(want.hit_int_port), 32'(got.hit_int_port));
		compare_field("hit_ext_port", 32'(want.hit_ext_port), 32'(got.hit_ext_port));
	endfunction

	function int pending();
		return expected_rsp_q.size();
	endfunction
endclass

module testbench;
	localparam int TABLE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	nat_table_scoreboard #(TABLE_DEPTH) sb;
	req_t inserted_q [$];
	bit   calm = 1'b1;
	int   stall_left = 0;
	int   cycles = 0;

	nat_mapping_table_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
		end
	end

	// mostly short gaps, now and then a long one
	function int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (calm) begin
			rsp_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	task automatic send_item(req_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		if (item.operation == OP_INSERT)
			inserted_q.push_back(item);
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic send_fields(logic [1:0] op, logic kind, logic [31:0] addr,
	                           logic [15:0] ip, logic [15:0] ep);
		req_t item;
		item.operation = op;
		item.map_type  = kind;
		item.int_addr  = addr;
		item.int_port  = ip;
		item.ext_port  = ep;
		send_item(item);
	endtask

	// step past the last accepting edge first so its item is already noted
	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function logic [31:0] pick_addr();
		if ($urandom_range(0, 1))
			return $urandom;
		case ($urandom_range(0, 3))
			0: return 32'h0A00_0001;
			1: return 32'hC0A8_0101;
			2: return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function logic [15:0] pick_port();
		if ($urandom_range(0, 1))
			return 16'($urandom_range(0, 7));
		return 16'($urandom_range(0, 65535));
	endfunction

	function req_t gen_item();
		req_t item;
		int   r;
		r = $urandom_range(0, 99);
		item.map_type = 1'($urandom_range(0, 1));
		item.int_addr = pick_addr();
		item.int_port = pick_port();
		item.ext_port = pick_port();
		if (r < 30)
			item.operation = OP_INSERT;
		else if (r < 62)
			item.operation = OP_LOOKUP_EXT;
		else if (r < 94)
			item.operation = OP_LOOKUP_INT;
		else
			item.operation = 2'(3);
		// aim most lookups at a stored mapping, sometimes with the other kind
		if ((item.operation == OP_LOOKUP_EXT || item.operation == OP_LOOKUP_INT)
		    && inserted_q.size() != 0 && $urandom_range(0, 99) < 65) begin
			r = $urandom_range(0, inserted_q.size() - 1);
			item.map_type = inserted_q[r].map_type ^ ($urandom_range(0, 99) < 15);
			item.int_addr = inserted_q[r].int_addr;
			item.int_port = inserted_q[r].int_port;
			item.ext_port = inserted_q[r].ext_port;
		end
		return item;
	endfunction

	initial begin
		int chunk;
		int k;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, unused operation, extremes, shadowing
		send_fields(OP_LOOKUP_EXT, 1'b0, 32'h0, 16'h0, 16'h0);
		send_fields(OP_LOOKUP_INT, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		send_fields(2'(3), 1'b0, 32'h0, 16'h0, 16'h0);
		send_fields(OP_INSERT, 1'b0, 32'h0, 16'h0, 16'h0);
		send_fields(OP_INSERT, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		send_fields(OP_LOOKUP_EXT, 1'b1, 32'h0, 16'h0, 16'hFFFF);
		send_fields(OP_LOOKUP_EXT, 1'b0, 32'h0, 16'h0, 16'hFFFF);
		send_fields(OP_LOOKUP_INT, 1'b0, 32'h0, 16'h0, 16'h0);
		send_fields(OP_LOOKUP_INT, 1'b1, 32'h0, 16'hFFFF, 16'h0);
		send_fields(OP_INSERT, 1'b0, 32'h0, 16'h0, 16'h1234);
		send_fields(OP_LOOKUP_INT, 1'b0, 32'h0, 16'h0, 16'h0);
		send_fields(OP_LOOKUP_EXT, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
		send_fields(2'(3), 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		send_fields(OP_INSERT, 1'b1, 32'hA5A5_A5A5, 16'h5A5A, 16'h0);
		send_fields(OP_LOOKUP_EXT, 1'b1, 32'h0, 16'h0, 16'h0);
		send_fields(OP_LOOKUP_INT, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
		send_fields(OP_LOOKUP_INT, 1'b1, 32'hA5A5_A5A4, 16'h5A5A, 16'h0);
		drain_results();

		for (chunk = 0; chunk < 5; chunk++) begin
			calm = (chunk == 2);
			for (k = 0; k < RANDOM_ITEMS / 5; k++)
				send_item(gen_item());
			if (chunk == 2)
				drain_results();
		end
		calm = 1'b0;

		drain_results();
		repeat (TABLE_DEPTH + 10) @(posedge clk);
		if (sb.fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

FILE: files.f
rtl/core/nmt_pkg.sv
rtl/core/nmt_datapath.sv
rtl/core/nmt_ctrl.sv
rtl/core/nat_mapping_table_unit.sv
dv/testbench.sv
